// ===== rtl/core/mstp_pkg.sv =====
// shared types and constants for the prim spanning tree block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package mstp_pkg;

	localparam int MAX_VERTICES = 32;
	localparam int IDX_BITS     = $clog2(MAX_VERTICES);
	localparam int ADDR_BITS    = 2 * IDX_BITS;
	localparam int ADJ_DEPTH    = 1 << ADDR_BITS;
	localparam int WEIGHT_BITS  = 16;
	localparam int KEY_BITS     = WEIGHT_BITS + 1;
	localparam int OP_BITS      = 2;
	localparam int VTX_BITS     = 5;
	localparam int CNT_BITS     = 6;
	localparam int CNT_RESET    = 32;

	typedef enum logic [OP_BITS-1:0] {
		OP_CLEAR = 2'd0,
		OP_ADD   = 2'd1,
		OP_RUN   = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef struct packed {
		logic                   en;
		logic [ADDR_BITS-1:0]   addr;
		logic [WEIGHT_BITS-1:0] data;
	} adj_wr_t;

	typedef struct packed {
		logic                   valid;
		logic [IDX_BITS-1:0]    low;
		logic [IDX_BITS-1:0]    high;
		logic [WEIGHT_BITS-1:0] weight;
		logic                   reachable;
		logic                   last;
	} emit_t;

	// only the upper triangle is stored: address is {smaller index, larger index}
	function automatic logic [ADDR_BITS-1:0] pair_addr(input logic [IDX_BITS-1:0] a,
		input logic [IDX_BITS-1:0] b);
		return (a < b) ? {a, b} : {b, a};
	endfunction

endpackage

// ===== rtl/core/mstp_adj_ram.sv =====
// adjacency weight store, one write and one registered read per cycle
// depends on mstp_pkg
`timescale 1ns / 1ps

module mstp_adj_ram (
	input  logic                               clk,
	input  mstp_pkg::adj_wr_t                  wr,
	input  logic [mstp_pkg::ADDR_BITS-1:0]     raddr,
	output logic [mstp_pkg::WEIGHT_BITS-1:0]   rdata
);
	import mstp_pkg::*;

	logic [WEIGHT_BITS-1:0] mem [ADJ_DEPTH];
	logic [WEIGHT_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/mstp_seq.sv =====
// sequencer for clear sweep, edge writes, prim rounds and result emission
// one shared key comparator serves both the minimum scan and the relaxation
// depends on mstp_pkg
`timescale 1ns / 1ps

module mstp_seq (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [mstp_pkg::IDX_BITS-1:0]      last_idx,
	input  logic                               in_fire,
	input  mstp_pkg::op_t                      op,
	input  logic [mstp_pkg::IDX_BITS-1:0]      vtx_a,
	input  logic [mstp_pkg::IDX_BITS-1:0]      vtx_b,
	input  logic                               vtx_ok,
	input  logic [mstp_pkg::WEIGHT_BITS-1:0]   weight,
	output logic                               idle,
	input  logic                               slot_free,
	output mstp_pkg::emit_t                    emit,
	output mstp_pkg::adj_wr_t                  adj_wr,
	output logic [mstp_pkg::ADDR_BITS-1:0]     adj_raddr,
	input  logic [mstp_pkg::WEIGHT_BITS-1:0]   adj_rdata
);
	import mstp_pkg::*;

	typedef enum logic [6:0] {
		ST_CLEAR   = 7'b0000001,
		ST_IDLE    = 7'b0000010,
		ST_SCAN    = 7'b0000100,
		ST_RELAX_A = 7'b0001000,
		ST_RELAX_B = 7'b0010000,
		ST_EMIT    = 7'b0100000,
		ST_SPARE   = 7'b1000000
	} state_t;

	localparam logic [KEY_BITS-1:0] KEY_INF = {1'b1, {WEIGHT_BITS{1'b0}}};

	state_t                 state_q;
	logic [ADDR_BITS-1:0]   clr_q;
	logic [IDX_BITS-1:0]    idx_q;
	logic                   found_q;
	logic [IDX_BITS-1:0]    pick_q;
	logic [KEY_BITS-1:0]    best_q;
	logic [KEY_BITS-1:0]    key_q [MAX_VERTICES];
	logic [IDX_BITS-1:0]    parent_q [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] in_tree_q;

	logic [KEY_BITS-1:0]    key_rd;
	logic                   tree_rd;
	logic [IDX_BITS-1:0]    parent_rd;
	logic [KEY_BITS-1:0]    cmp_a;
	logic [KEY_BITS-1:0]    cmp_b;
	logic                   cmp_lt;
	logic                   scan_take;
	logic [IDX_BITS-1:0]    pick_d;
	logic [KEY_BITS-1:0]    best_d;
	logic                   found_d;
	logic                   relax_upd;
	logic                   at_last;
	logic                   emit_ok;

	assign key_rd    = key_q[idx_q];
	assign tree_rd   = in_tree_q[idx_q];
	assign parent_rd = parent_q[idx_q];
	assign at_last   = (idx_q == last_idx);

	// shared comparator: scan compares against the running minimum,
	// relaxation compares the edge weight against the stored key
	always_comb begin
		case (state_q)
			ST_RELAX_B: begin
				cmp_a = {1'b0, adj_rdata};
				cmp_b = key_rd;
			end
			default: begin
				cmp_a = key_rd;
				cmp_b = best_q;
			end
		endcase
	end
	assign cmp_lt = (cmp_a < cmp_b);

	assign scan_take = !tree_rd && (!found_q || cmp_lt);
	assign pick_d    = scan_take ? idx_q : pick_q;
	assign best_d    = scan_take ? key_rd : best_q;
	assign found_d   = found_q || scan_take;
	assign relax_upd = (state_q == ST_RELAX_B) && (adj_rdata != '0) && !tree_rd && cmp_lt;

	assign adj_raddr = pair_addr(pick_q, idx_q);
	assign idle      = (state_q == ST_IDLE);

	always_comb begin
		if (state_q == ST_CLEAR) begin
			adj_wr.en   = 1'b1;
			adj_wr.addr = clr_q;
			adj_wr.data = '0;
		end else begin
			adj_wr.en   = in_fire && (op == OP_ADD) && vtx_ok;
			adj_wr.addr = pair_addr(vtx_a, vtx_b);
			adj_wr.data = weight;
		end
	end

	// unreachable vertices keep an infinite key
	assign emit_ok = !key_rd[WEIGHT_BITS];
	always_comb begin
		emit.valid     = (state_q == ST_EMIT) && slot_free;
		emit.reachable = emit_ok;
		emit.last      = at_last;
		if (emit_ok) begin
			emit.low    = (parent_rd < idx_q) ? parent_rd : idx_q;
			emit.high   = (parent_rd < idx_q) ? idx_q : parent_rd;
			emit.weight = key_rd[WEIGHT_BITS-1:0];
		end else begin
			emit.low    = '0;
			emit.high   = idx_q;
			emit.weight = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			idx_q   <= '0;
			found_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_BITS'(ADJ_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_fire) begin
						case (op)
							OP_CLEAR: begin
								state_q <= ST_CLEAR;
								clr_q   <= '0;
							end
							OP_RUN: begin
								state_q <= ST_SCAN;
								idx_q   <= '0;
								found_q <= 1'b0;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (at_last) begin
						found_q <= 1'b0;
						if (!found_d) begin
							state_q <= ST_EMIT;
							idx_q   <= IDX_BITS'(1);
						end else if (best_d[WEIGHT_BITS]) begin
							// picked vertex is unreached: nothing to relax
							state_q <= ST_SCAN;
							idx_q   <= '0;
						end else begin
							state_q <= ST_RELAX_A;
							idx_q   <= '0;
						end
					end else begin
						found_q <= found_d;
						idx_q   <= idx_q + 1'b1;
					end
				end
				ST_RELAX_A: begin
					state_q <= ST_RELAX_B;
				end
				ST_RELAX_B: begin
					if (at_last) begin
						state_q <= ST_SCAN;
						idx_q   <= '0;
						found_q <= 1'b0;
					end else begin
						state_q <= ST_RELAX_A;
						idx_q   <= idx_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						if (at_last) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_fire && op == OP_RUN) begin
			in_tree_q <= '0;
			// the root starts at key zero, every other vertex at infinity
			for (int i = 0; i < MAX_VERTICES; i++) begin
				key_q[i] <= (i == 0) ? '0 : KEY_INF;
			end
		end
		if (state_q == ST_SCAN) begin
			pick_q <= pick_d;
			best_q <= best_d;
			if (at_last && found_d) begin
				in_tree_q[pick_d] <= 1'b1;
			end
		end
		if (relax_upd) begin
			key_q[idx_q]    <= {1'b0, adj_rdata};
			parent_q[idx_q] <= pick_q;
		end
	end

	a_emit_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		emit.valid |-> slot_free)
		else $error("result issued with output register occupied");

	a_emit_skips_root: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> idx_q != '0)
		else $error("result issued for the root vertex");

	a_relax_pick_in_tree: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RELAX_A |-> in_tree_q[pick_q])
		else $error("relaxing from a vertex not yet in the tree");

	a_root_key_zero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> key_q[0] == '0)
		else $error("root key disturbed during a run");

endmodule

// ===== rtl/core/min_spanning_tree_prim.sv =====
// top level of the prim spanning tree block: config register, output register
// depends on mstp_pkg, mstp_adj_ram and mstp_seq
//
// input channel (in_valid/in_ready) takes one command per transaction:
// operation 0 clears the weight matrix, 1 writes a symmetric edge,
// 2 runs prim from vertex 0, 3 is ignored. output channel (out_valid/out_ready)
// carries one tree edge per vertex 1..n-1 in vertex order, last_edge on the final one.
// cfg_wr_en/cfg_wr_data write vertex_count (n), clamped to 2..32; write only when idle.
// edge write and ignored command: the block stays idle, and the next command is taken the cycle after.
// clear sweeps every matrix word, one per cycle through the single write port.
// run: each round scans the n keys; a round whose vertex is reached then relaxes
// n neighbours, each through ST_RELAX_A then ST_RELAX_B (registered matrix read), and
// after the search the n-1 results follow without pause while out_ready stays high.
// reset: vertex_count returns to 32 and a clearing pass zeroes
// the matrix; in_ready stays low until it ends.
// a stalled receiver holds the result in the output register and the run
// pauses until that transaction completes; in_ready stays low throughout a run.
`timescale 1ns / 1ps

module min_spanning_tree_prim (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [mstp_pkg::CNT_BITS-1:0]      cfg_wr_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [mstp_pkg::OP_BITS-1:0]       operation,
	input  logic [mstp_pkg::VTX_BITS-1:0]      first_vertex,
	input  logic [mstp_pkg::VTX_BITS-1:0]      second_vertex,
	input  logic [mstp_pkg::WEIGHT_BITS-1:0]   edge_weight,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [mstp_pkg::VTX_BITS-1:0]      low_endpoint,
	output logic [mstp_pkg::VTX_BITS-1:0]      high_endpoint,
	output logic [mstp_pkg::WEIGHT_BITS-1:0]   tree_weight,
	output logic                               reachable,
	output logic                               last_edge
);
	import mstp_pkg::*;

	logic [CNT_BITS-1:0]    vertex_count_q;
	logic [IDX_BITS-1:0]    last_idx;
	logic                   idle;
	logic                   in_fire;
	logic                   vtx_ok;
	logic                   slot_free;
	emit_t                  emit;
	adj_wr_t                adj_wr;
	logic [ADDR_BITS-1:0]   adj_raddr;
	logic [WEIGHT_BITS-1:0] adj_rdata;

	logic                   out_valid_q;
	logic [IDX_BITS-1:0]    low_q;
	logic [IDX_BITS-1:0]    high_q;
	logic [WEIGHT_BITS-1:0] weight_q;
	logic                   reach_q;
	logic                   last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= CNT_BITS'(CNT_RESET);
		end else if (cfg_wr_en) begin
			vertex_count_q <= cfg_wr_data;
		end
	end

	// highest vertex index in use, after clamping the count
	always_comb begin
		if (int'(vertex_count_q) < 2) begin
			last_idx = IDX_BITS'(1);
		end else if (int'(vertex_count_q) > MAX_VERTICES) begin
			last_idx = IDX_BITS'(MAX_VERTICES - 1);
		end else begin
			last_idx = IDX_BITS'(vertex_count_q - 1'b1);
		end
	end

	assign in_ready  = idle;
	assign in_fire   = in_valid && idle;
	assign vtx_ok    = (int'(first_vertex) < MAX_VERTICES) && (int'(second_vertex) < MAX_VERTICES);
	assign slot_free = !out_valid_q || out_ready;

	mstp_adj_ram u_adj_ram (
		.clk   (clk),
		.wr    (adj_wr),
		.raddr (adj_raddr),
		.rdata (adj_rdata)
	);

	mstp_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.last_idx  (last_idx),
		.in_fire   (in_fire),
		.op        (op_t'(operation)),
		.vtx_a     (IDX_BITS'(first_vertex)),
		.vtx_b     (IDX_BITS'(second_vertex)),
		.vtx_ok    (vtx_ok),
		.weight    (edge_weight),
		.idle      (idle),
		.slot_free (slot_free),
		.emit      (emit),
		.adj_wr    (adj_wr),
		.adj_raddr (adj_raddr),
		.adj_rdata (adj_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid) begin
			low_q    <= emit.low;
			high_q   <= emit.high;
			weight_q <= emit.weight;
			reach_q  <= emit.reachable;
			last_q   <= emit.last;
		end
	end

	assign out_valid     = out_valid_q;
	assign low_endpoint  = VTX_BITS'(low_q);
	assign high_endpoint = VTX_BITS'(high_q);
	assign tree_weight   = weight_q;
	assign reachable     = reach_q;
	assign last_edge     = last_q;

endmodule
